// File: hdl/ifhg_pkg.sv
// Package for the IPv4 fragment header generator.
// Holds the controller/datapath command and status types, state encoding,
// register indexes and fixed header constants. No dependencies.
package ifhg_pkg;

    // Fixed widths of the stream and configuration payloads
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL      = 8'd1;

    // Header constants
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [10:0] HDR_BYTES   = 11'd20;
    localparam logic [7:0]  TTL_RESET   = 8'd64;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take a new packet descriptor
        logic emit;   // load the next fragment into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic final_frag; // the fragment on offer is the final one
        logic out_free;   // output register can take a fragment this cycle
    } t_dp_status;

endpackage

// File: hdl/ifhg_ctrl.sv
// Controller state machine for the IPv4 fragment header generator.
// Sequences packet acceptance and fragment emission; uses ifhg_pkg.
module ifhg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ifhg_pkg::t_dp_status  i_status,
    output ifhg_pkg::t_dp_cmd     o_cmd
);

    ifhg_pkg::t_state r_state;
    ifhg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ifhg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ifhg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ifhg_pkg::ST_EMIT;
                end
            end
            ifhg_pkg::ST_EMIT: begin
                if (i_status.out_free && i_status.final_frag) begin
                    n_state = ifhg_pkg::ST_IDLE;
                end
            end
            default: n_state = ifhg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ifhg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ifhg_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/ifhg_dp.sv
// Datapath for the IPv4 fragment header generator: configuration registers,
// fragment counters, checksum and output register. Uses ifhg_pkg.
module ifhg_dp #(
    parameter int unsigned FRAG_PAYLOAD = 1480
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ifhg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ifhg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [15:0]                         i_payload_len,
    input  logic [31:0]                         i_dest_address,
    input  logic [7:0]                          i_proto_number,
    input  ifhg_pkg::t_dp_cmd                   i_cmd,
    output ifhg_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [10:0]                         o_total_length,
    output logic [15:0]                         o_ident,
    output logic [12:0]                         o_frag_offset,
    output logic                                o_more_frags,
    output logic [15:0]                         o_header_sum,
    output logic [31:0]                         o_dest_out,
    output logic [7:0]                          o_proto_out,
    output logic                                o_last
);

    localparam logic [15:0] FRAG_LEN = 16'(FRAG_PAYLOAD);

    // Configuration
    logic [31:0] r_src_addr;
    logic [7:0]  r_ttl;

    // Per-packet state
    logic [15:0] r_next_ident;
    logic [15:0] r_ident;
    logic [15:0] r_bytes_left;
    logic [15:0] r_byte_pos;
    logic [31:0] r_dest;
    logic [7:0]  r_proto;
    logic [18:0] r_base_sum;

    // Output register
    logic        r_out_valid;
    logic [10:0] r_total_length;
    logic [15:0] r_ident_out;
    logic [12:0] r_frag_offset;
    logic        r_more_frags;
    logic [15:0] r_header_sum;
    logic [31:0] r_dest_out;
    logic [7:0]  r_proto_out;

    logic [18:0] base_sum;
    logic        more;
    logic [10:0] piece;
    logic [10:0] tot;
    logic [12:0] off;
    logic [15:0] flagoff;
    logic [19:0] frag_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // Sum of the header words that stay fixed over a packet
    assign base_sum = 19'(ifhg_pkg::VER_IHL_TOS)
                    + 19'(r_next_ident)
                    + 19'({r_ttl, i_proto_number})
                    + 19'(r_src_addr[31:16])
                    + 19'(r_src_addr[15:0])
                    + 19'(i_dest_address[31:16])
                    + 19'(i_dest_address[15:0]);

    assign more     = r_bytes_left > FRAG_LEN;
    assign piece    = more ? FRAG_LEN[10:0] : r_bytes_left[10:0];
    assign tot      = piece + ifhg_pkg::HDR_BYTES;
    assign off      = r_byte_pos[15:3];
    assign flagoff  = {2'b00, more, off};
    assign frag_sum = 20'(r_base_sum) + 20'(tot) + 20'(flagoff);
    // End-around carry; two folds are enough for this width
    assign fold1    = 17'(frag_sum[15:0]) + 17'(frag_sum[19:16]);
    assign fold2    = fold1[15:0] + 16'(fold1[16]);

    assign o_status.final_frag = !more;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= '0;
            r_ttl      <= ifhg_pkg::TTL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ifhg_pkg::CFG_SRC_ADDR: r_src_addr <= i_cfg_data;
                ifhg_pkg::CFG_TTL:      r_ttl      <= i_cfg_data[7:0];
                default:                r_ttl      <= r_ttl;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_ident <= '0;
            r_bytes_left <= '0;
            r_byte_pos   <= '0;
        end else if (i_cmd.load) begin
            r_bytes_left <= i_payload_len;
            r_byte_pos   <= '0;
        end else if (i_cmd.emit) begin
            r_bytes_left <= r_bytes_left - 16'(piece);
            r_byte_pos   <= r_byte_pos + 16'(piece);
            if (!more) begin
                r_next_ident <= r_next_ident + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ident    <= r_next_ident;
            r_dest     <= i_dest_address;
            r_proto    <= i_proto_number;
            r_base_sum <= base_sum;
        end
    end

    // Hold the descriptor until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_total_length <= tot;
            r_ident_out    <= r_ident;
            r_frag_offset  <= off;
            r_more_frags   <= more;
            r_header_sum   <= ~fold2;
            r_dest_out     <= r_dest;
            r_proto_out    <= r_proto;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_total_length = r_total_length;
    assign o_ident        = r_ident_out;
    assign o_frag_offset  = r_frag_offset;
    assign o_more_frags   = r_more_frags;
    assign o_header_sum   = r_header_sum;
    assign o_dest_out     = r_dest_out;
    assign o_proto_out    = r_proto_out;
    assign o_last         = !r_more_frags;

endmodule

// File: hdl/ipv4_fragment_header_gen_unit.sv
// IPv4 fragment header generator: one packet descriptor in, one header
// descriptor per fragment out. A packet that splits into N fragments
// (N = ceil(payload_len / FRAG_PAYLOAD), at least one) is handled in two steps:
// the block takes the packet descriptor and sums the fixed header words, then
// emits the fragments in order, each as the output register has room. The input
// is taken again in the cycle after the final fragment enters the output
// register, even while that descriptor still waits to be taken. Source address
// and TTL are to be written through the configuration channel only while the
// block is idle; the user is bound to this, the block itself does not enforce it.
module ipv4_fragment_header_gen_unit #(
    parameter int unsigned FRAG_PAYLOAD = 1480
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ifhg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ifhg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Packet descriptors in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // payload_len[15:0], dest_address[47:16], proto_number[55:48]
    input  logic [ifhg_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // Fragment header descriptors out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // total_length[10:0], ident[26:11], frag_offset[39:27], more_frags[40],
    // header_sum[56:41], dest_out[88:57], proto_out[96:89], zero[103:97]
    output logic [ifhg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);

    ifhg_pkg::t_dp_cmd    cmd;
    ifhg_pkg::t_dp_status status;

    logic [10:0] total_length;
    logic [15:0] ident;
    logic [12:0] frag_offset;
    logic        more_frags;
    logic [15:0] header_sum;
    logic [31:0] dest_out;
    logic [7:0]  proto_out;

    assign o_cfg_ready = 1'b1;

    ifhg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ifhg_dp #(
        .FRAG_PAYLOAD (FRAG_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_payload_len  (s_axis_tdata[15:0]),
        .i_dest_address (s_axis_tdata[47:16]),
        .i_proto_number (s_axis_tdata[55:48]),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_total_length (total_length),
        .o_ident        (ident),
        .o_frag_offset  (frag_offset),
        .o_more_frags   (more_frags),
        .o_header_sum   (header_sum),
        .o_dest_out     (dest_out),
        .o_proto_out    (proto_out),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, proto_out, dest_out, header_sum, more_frags,
                           frag_offset, ident, total_length};

`ifndef NO_ASSERTIONS
    // The final fragment is the only one with MF clear
    a_last_mf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == !m_axis_tdata[40]))
        else $error("tlast disagrees with more_frags");

    // No new packet while its fragments are still being produced
    a_one_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("packet accepted while fragments pending");

    // A non-final fragment taken is followed at once by the next one
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap between fragments of one packet");
`endif

endmodule

// File: tb/sv/ipv4_fragment_header_gen_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_fragment_header_gen_unit: predicts every fragment
// header descriptor from the packet descriptors sent, and compares it field by field.
// Depends on ifhg_pkg and the unit under test only.
module ipv4_fragment_header_gen_unit_test;

    localparam int unsigned FRAG_BYTES    = 1480;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 60;
    localparam logic [ifhg_pkg::CFG_IDX_W-1:0] CFG_IDX_MAX = {ifhg_pkg::CFG_IDX_W{1'b1}};

    typedef logic [ifhg_pkg::CFG_IDX_W-1:0] t_cfg_idx;

    typedef struct packed {
        logic [10:0] total_length;
        logic [15:0] ident;
        logic [12:0] frag_offset;
        logic        more_frags;
        logic [15:0] header_sum;
        logic [31:0] dest_out;
        logic [7:0]  proto_out;
        logic        last;
    } t_frag_hdr;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_valid   = 1'b0;
    logic [ifhg_pkg::CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [ifhg_pkg::CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                              o_cfg_ready;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // payload_len[15:0], dest_address[47:16], proto_number[55:48]
    logic [ifhg_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // total_length[10:0], ident[26:11], frag_offset[39:27], more_frags[40],
    // header_sum[56:41], dest_out[88:57], proto_out[96:89], zero[103:97]
    logic [ifhg_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tlast;

    // Shadow of the block's registers and identification counter
    logic [31:0] src_addr_shadow;
    logic [7:0]  ttl_shadow;
    logic [15:0] next_ident_shadow;

    t_frag_hdr   frag_expect_q[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned packets_sent = 0;
    int unsigned frags_checked = 0;
    int unsigned cfg_writes = 0;
    int unsigned quiet_cycles = 0;

    ipv4_fragment_header_gen_unit #(
        .FRAG_PAYLOAD (FRAG_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [15:0] header_checksum(logic [10:0] tot, logic [15:0] id,
                                                    logic [15:0] flagoff, logic [7:0] proto,
                                                    logic [31:0] dst);
        logic [31:0] acc;
        acc = 32'(ifhg_pkg::VER_IHL_TOS) + 32'(tot) + 32'(id) + 32'(flagoff)
            + 32'({ttl_shadow, proto})
            + 32'(src_addr_shadow[31:16]) + 32'(src_addr_shadow[15:0])
            + 32'(dst[31:16]) + 32'(dst[15:0]);
        while (acc[31:16] != 16'd0)
            acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        return ~acc[15:0];
    endfunction

    // Queue one descriptor per fragment, in order of offset
    task automatic predict_fragments(logic [15:0] len, logic [31:0] dst, logic [7:0] proto);
        logic [15:0] remaining;
        logic [15:0] pos;
        logic [15:0] piece;
        logic        mf;
        t_frag_hdr   f;
        remaining = len;
        pos = 16'd0;
        do begin
            if (remaining > FRAG_BYTES) begin
                piece = 16'(FRAG_BYTES);
                mf = 1'b1;
            end else begin
                piece = remaining;
                mf = 1'b0;
            end
            f.total_length = 11'(piece) + ifhg_pkg::HDR_BYTES;
            f.ident        = next_ident_shadow;
            f.frag_offset  = pos[15:3];
            f.more_frags   = mf;
            f.header_sum   = header_checksum(f.total_length, next_ident_shadow,
                                             {2'b00, mf, pos[15:3]}, proto, dst);
            f.dest_out     = dst;
            f.proto_out    = proto;
            f.last         = ~mf;
            frag_expect_q.push_back(f);
            remaining = remaining - piece;
            pos = pos + piece;
        end while (mf);
        next_ident_shadow = next_ident_shadow + 16'd1;
    endtask

    // Valid is left high after the transaction so back-to-back packets keep it asserted
    task automatic send_packet(logic [15:0] len, logic [31:0] dst, logic [7:0] proto);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {proto, dst, len};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_fragments(len, dst, proto);
        packets_sent++;
    endtask

    // Drop valid and hold until every expected fragment has been taken
    task automatic pause_for_fragments();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (frag_expect_q.size() != 0);
    endtask

    task automatic write_register(logic [ifhg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ifhg_pkg::CFG_SRC_ADDR)
            src_addr_shadow = value;
        else if (idx == ifhg_pkg::CFG_TTL)
            ttl_shadow = value[7:0];
        cfg_writes++;
    endtask

    // Stray writes go last so that aliasing onto a real register shows up
    task automatic apply_settings(logic [31:0] src, logic [7:0] ttl, bit with_stray);
        pause_for_fragments();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(ifhg_pkg::CFG_SRC_ADDR, src);
        write_register(ifhg_pkg::CFG_TTL, {24'd0, ttl});
        if (with_stray) begin
            write_register(t_cfg_idx'($urandom_range(ifhg_pkg::CFG_TTL + 1, CFG_IDX_MAX)),
                           $urandom());
            write_register(CFG_IDX_MAX, $urandom());
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin : check_fragments
        t_frag_hdr want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frag_expect_q.size() == 0) begin
                $display("%0t: fragment with none expected: expected nothing, got 0x%0h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = frag_expect_q.pop_front();
                check_field("total_length", 32'(want.total_length), 32'(m_axis_tdata[10:0]));
                check_field("ident",        32'(want.ident),        32'(m_axis_tdata[26:11]));
                check_field("frag_offset",  32'(want.frag_offset),  32'(m_axis_tdata[39:27]));
                check_field("more_frags",   32'(want.more_frags),   32'(m_axis_tdata[40]));
                check_field("header_sum",   32'(want.header_sum),   32'(m_axis_tdata[56:41]));
                check_field("dest_out",     want.dest_out,          m_axis_tdata[88:57]);
                check_field("proto_out",    32'(want.proto_out),    32'(m_axis_tdata[96:89]));
                check_field("pad",          32'd0,                  32'(m_axis_tdata[103:97]));
                check_field("last",         32'(want.last),         32'(m_axis_tlast));
                frags_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("ipv4_fragment_header_gen_unit test failed");
                $finish;
            end
        end
    end

    // Reset settings: empty payload, one byte, fragment boundaries
    task automatic test_reset_defaults();
        send_packet(16'd0, 32'hC0A8_0001, 8'd17);
        send_packet(16'd1, 32'h0A00_0002, 8'd6);
        send_packet(16'(FRAG_BYTES), 32'h0102_0304, 8'd1);
        send_packet(16'(FRAG_BYTES + 1), 32'hFFFF_FFFF, 8'd255);
        send_packet(16'(2 * FRAG_BYTES), 32'h0000_0000, 8'd0);
    endtask

    task automatic test_length_extremes();
        send_packet(16'd65515, 32'hFFFF_FFFF, 8'hFF);
        // Beyond the stated range, up to the largest packet
        send_packet(16'd65535, 32'h0000_0000, 8'h00);
        send_packet(16'd65520, 32'hA5A5_5A5A, 8'h5A);
        send_packet(16'(44 * FRAG_BYTES), 32'h5A5A_A5A5, 8'hA5);
        send_packet(16'(FRAG_BYTES - 1), 32'h8000_0001, 8'h80);
        send_packet(16'd7, 32'h7FFF_FFFE, 8'h7F);
        send_packet(16'd8, 32'h1234_5678, 8'd50);
    endtask

    task automatic test_register_extremes();
        apply_settings(32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_packet(16'd0, 32'hFFFF_FFFF, 8'hFF);
        send_packet(16'(3 * FRAG_BYTES), 32'hFFFF_FFFF, 8'hFF);
        send_packet(16'd2000, 32'h0000_0001, 8'd6);
        apply_settings(32'h0000_0000, 8'h00, 1'b1);
        send_packet(16'd0, 32'h0000_0000, 8'h00);
        send_packet(16'(FRAG_BYTES + 8), 32'hC633_6401, 8'd17);
        send_packet(16'd1024, 32'hDEAD_BEEF, 8'd132);
    endtask

    function automatic logic [15:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 16'($urandom_range(0, 3 * FRAG_BYTES));
        else if (r < 70)
            return 16'($urandom_range(1, 6) * FRAG_BYTES + $urandom_range(0, 2) - 1);
        else if (r < 82)
            return 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(0, 20));
    endfunction

    task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                       int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        apply_settings($urandom(), 8'($urandom_range(0, 255)), 1'($urandom_range(1)));
        for (int unsigned i = 0; i < count; i++) begin
            if (i == count / 2) begin
                if ($urandom_range(1))
                    apply_settings($urandom(), 8'($urandom_range(0, 255)),
                                   1'($urandom_range(1)));
                else
                    pause_for_fragments();
            end
            send_packet(pick_length(), $urandom(), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        src_addr_shadow   = 32'd0;
        ttl_shadow        = ifhg_pkg::TTL_RESET;
        next_ident_shadow = 16'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_length_extremes();
        test_register_extremes();
        test_random_traffic(32, 8, 53);
        test_random_traffic(32, 53, 8);
        test_random_traffic(28, 0, 0);

        pause_for_fragments();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (frag_expect_q.size() != 0) begin
            $display("%0t: %0d expected fragments never arrived", $time, frag_expect_q.size());
            mismatch_count++;
        end
        $display("Covered %0d packets and %0d fragment descriptors, %0d register writes,",
                 packets_sent, frags_checked, cfg_writes);
        $display("empty to largest payloads, extreme TTL and source values, stalls on both sides.");
        if (mismatch_count == 0)
            $display("ipv4_fragment_header_gen_unit test passed");
        else
            $display("ipv4_fragment_header_gen_unit test failed");
        $finish;
    end
endmodule

// File: sim.f
hdl/ifhg_pkg.sv
hdl/ifhg_ctrl.sv
hdl/ifhg_dp.sv
hdl/ipv4_fragment_header_gen_unit.sv
tb/sv/ipv4_fragment_header_gen_unit_test.sv
